>>> hw/rtl/rai_pkg.sv
// Shared definitions for the ray versus axis-aligned rectangle test.
// Holds the plane axis codes, the register indexes and the flag struct; no dependencies.
package rai_pkg;

    localparam int REG_IDX_BITS = 3;

    localparam logic [1:0] AXIS_XY = 2'd0;
    localparam logic [1:0] AXIS_XZ = 2'd1;
    localparam logic [1:0] AXIS_YZ = 2'd2;

    localparam logic [REG_IDX_BITS-1:0] REG_PLANE_AXIS   = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_PLANE_OFFSET = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_FIRST_LOW    = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_FIRST_HIGH   = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_SECOND_LOW   = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_SECOND_HIGH  = 3'd5;

    typedef struct packed {
        logic miss;
        logic neg_q;
        logic front_face;
    } rai_flags_t;

    localparam int FLAG_BITS = $bits(rai_flags_t);

endpackage

>>> hw/rtl/rai_front.sv
// Front stage: accepts rays, picks the normal and in-plane axes and prepares the t division.
// Depends on rai_pkg.
module rai_front
    import rai_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [W-1:0]     origin_x,
    input  logic [W-1:0]     origin_y,
    input  logic [W-1:0]     origin_z,
    input  logic [W-1:0]     dir_x,
    input  logic [W-1:0]     dir_y,
    input  logic [W-1:0]     dir_z,
    input  logic [W-1:0]     t_lower,
    input  logic [W-1:0]     t_upper,
    input  logic [1:0]       plane_axis,
    input  logic [W-1:0]     plane_offset,
    output logic             out_valid,
    input  logic             out_ready,
    output rai_flags_t       out_flags,
    output logic [W+F-1:0]   out_num,
    output logic [W-1:0]     out_den,
    output logic [W-1:0]     out_oa,
    output logic [W-1:0]     out_ob,
    output logic [W-1:0]     out_da,
    output logic [W-1:0]     out_db,
    output logic [W-1:0]     out_tlo,
    output logic [W-1:0]     out_thi
);

    logic [W-1:0] o_n, d_n, o_a, d_a, o_b, d_b;
    logic         axis_ok;
    logic [W:0]   diff, diff_abs;
    logic         valid_reg;
    rai_flags_t   flags_next;

    always_comb
    begin
        axis_ok = 1'b1;
        o_n = origin_z; d_n = dir_z;
        o_a = origin_x; d_a = dir_x;
        o_b = origin_y; d_b = dir_y;
        unique case (plane_axis)
            AXIS_XY:
            begin
                o_n = origin_z; d_n = dir_z;
            end
            AXIS_XZ:
            begin
                o_n = origin_y; d_n = dir_y;
                o_b = origin_z; d_b = dir_z;
            end
            AXIS_YZ:
            begin
                o_n = origin_x; d_n = dir_x;
                o_a = origin_y; d_a = dir_y;
                o_b = origin_z; d_b = dir_z;
            end
            default:
            begin
                axis_ok = 1'b0;
            end
        endcase
    end

    assign diff     = {plane_offset[W-1], plane_offset} - {o_n[W-1], o_n};
    assign diff_abs = diff[W] ? (~diff + 1'b1) : diff;

    assign flags_next.miss       = ~axis_ok | (d_n == '0);
    assign flags_next.neg_q      = diff[W] ^ d_n[W-1];
    assign flags_next.front_face = d_n[W-1];

    assign in_ready  = ~valid_reg | out_ready;
    assign out_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            out_flags <= flags_next;
            out_num   <= {diff_abs[W-1:0], {F{1'b0}}};
            out_den   <= d_n[W-1] ? (~d_n + 1'b1) : d_n;
            out_oa    <= o_a;
            out_ob    <= o_b;
            out_da    <= d_a;
            out_db    <= d_b;
            out_tlo   <= t_lower;
            out_thi   <= t_upper;
        end
    end

endmodule

>>> hw/rtl/rai_fifo.sv
// Short queue between the front and back stages; DEPTH must be a power of two.
// No dependencies.
module rai_fifo #(
    parameter int DW    = 8,
    parameter int DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [DW-1:0] in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [DW-1:0] out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push, pop;

    assign in_ready  = count_reg != CW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

>>> hw/rtl/rai_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband carried alongside.
// The initial remainder must be below the divisor for a meaningful quotient. No dependencies.
module rai_div #(
    parameter int NW = 16,
    parameter int DW = 16,
    parameter int SW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [NW-1:0] out_quo,
    output logic [SW-1:0] out_side
);

    logic [DW+NW-1:0] z_reg    [NW];
    logic [DW-1:0]    den_reg  [NW];
    logic [SW-1:0]    side_reg [NW];
    logic             vld_reg  [NW];

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic [DW+NW-1:0] z_in, z_next;
        logic [DW-1:0]    d_in;
        logic [SW-1:0]    s_in;
        logic             v_in;
        logic [DW:0]      top, diff;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign z_in = {in_rem, in_num};
            assign d_in = in_den;
            assign s_in = in_side;
            assign v_in = in_valid;
        end
        else
        begin : g_next
            assign z_in = z_reg[k-1];
            assign d_in = den_reg[k-1];
            assign s_in = side_reg[k-1];
            assign v_in = vld_reg[k-1];
        end

        assign top    = z_in[DW+NW-1:NW-1];
        assign ge     = top >= {1'b0, d_in};
        assign diff   = top - {1'b0, d_in};
        assign z_next = {ge ? diff[DW-1:0] : top[DW-1:0], z_in[NW-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                z_reg[k]    <= z_next;
                den_reg[k]  <= d_in;
                side_reg[k] <= s_in;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign out_quo   = z_reg[NW-1][NW-1:0];
    assign out_side  = side_reg[NW-1];

endmodule

>>> hw/rtl/rai_back.sv
// Back pipeline: t division, window check, hit point, bounds check and u/v division.
// Depends on rai_pkg and rai_div.
module rai_back
    import rai_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rai_flags_t     in_flags,
    input  logic [W+F-1:0] in_num,
    input  logic [W-1:0]   in_den,
    input  logic [W-1:0]   in_oa,
    input  logic [W-1:0]   in_ob,
    input  logic [W-1:0]   in_da,
    input  logic [W-1:0]   in_db,
    input  logic [W-1:0]   in_tlo,
    input  logic [W-1:0]   in_thi,
    input  logic [W-1:0]   first_low,
    input  logic [W-1:0]   first_high,
    input  logic [W-1:0]   second_low,
    input  logic [W-1:0]   second_high,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           hit,
    output logic [W-1:0]   hit_t,
    output logic [W-1:0]   hit_first,
    output logic [W-1:0]   hit_second,
    output logic [F:0]     tex_u,
    output logic [F:0]     tex_v,
    output logic           front_face
);

    localparam int TW     = W + F + 1;
    localparam int FW     = 2 * W - F + 1;
    localparam int SIDE_T = FLAG_BITS + 6 * W;
    localparam int SIDE_U = 4 + 3 * W;

    logic en;
    logic valid_reg;

    assign en        = ~valid_reg | out_ready;
    assign in_ready  = en;
    assign out_valid = valid_reg;

    // t division
    logic              dt_valid;
    logic [W+F-1:0]    dt_quo;
    logic [SIDE_T-1:0] dt_side;
    rai_flags_t        dt_flags;
    logic [W-1:0]      dt_oa, dt_ob, dt_da, dt_db, dt_tlo, dt_thi;

    rai_div #(.NW(W + F), .DW(W), .SW(SIDE_T)) u_div_t (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .in_rem   ({W{1'b0}}),
        .in_num   (in_num),
        .in_den   (in_den),
        .in_side  ({in_flags, in_oa, in_ob, in_da, in_db, in_tlo, in_thi}),
        .out_valid(dt_valid),
        .out_quo  (dt_quo),
        .out_side (dt_side)
    );

    assign {dt_flags, dt_oa, dt_ob, dt_da, dt_db, dt_tlo, dt_thi} = dt_side;

    // Stage A: apply the quotient sign.
    logic            a_v_reg;
    rai_flags_t      a_flags_reg;
    logic [TW-1:0]   a_t_reg, a_t_next;
    logic [W-1:0]    a_oa_reg, a_ob_reg, a_da_reg, a_db_reg, a_tlo_reg, a_thi_reg;

    assign a_t_next = dt_flags.neg_q ? (~{1'b0, dt_quo} + 1'b1) : {1'b0, dt_quo};

    // Stage B: window check; t narrows to a word, which is exact for values inside the window.
    logic          b_v_reg, b_miss_reg, b_ff_reg, b_miss_next;
    logic [W-1:0]  b_t_reg, b_oa_reg, b_ob_reg, b_da_reg, b_db_reg;
    logic [TW-1:0] tlo_ext, thi_ext;

    assign tlo_ext     = {{(F+1){a_tlo_reg[W-1]}}, a_tlo_reg};
    assign thi_ext     = {{(F+1){a_thi_reg[W-1]}}, a_thi_reg};
    assign b_miss_next = a_flags_reg.miss
                       | ($signed(a_t_reg) < $signed(tlo_ext))
                       | ($signed(a_t_reg) > $signed(thi_ext));

    // Stage C: products of t with the in-plane direction components.
    logic                  c_v_reg, c_miss_reg, c_ff_reg;
    logic [W-1:0]          c_t_reg, c_oa_reg, c_ob_reg;
    logic signed [2*W-1:0] c_pa_reg, c_pb_reg, c_pa_next, c_pb_next;

    assign c_pa_next = $signed(b_t_reg) * $signed(b_da_reg);
    assign c_pb_next = $signed(b_t_reg) * $signed(b_db_reg);

    // Stage D: hit point, the arithmetic shift rounds toward minus infinity.
    logic          d_v_reg, d_miss_reg, d_ff_reg;
    logic [W-1:0]  d_t_reg;
    logic [FW-1:0] d_f_reg, d_s_reg, d_f_next, d_s_next;

    assign d_f_next = {{(W-F+1){c_oa_reg[W-1]}}, c_oa_reg}
                    + {c_pa_reg[2*W-1], c_pa_reg[2*W-1:F]};
    assign d_s_next = {{(W-F+1){c_ob_reg[W-1]}}, c_ob_reg}
                    + {c_pb_reg[2*W-1], c_pb_reg[2*W-1:F]};

    // Stage E: bounds check and the operands of the u and v divisions.
    logic          e_v_reg, e_miss_reg, e_ff_reg, e_miss_next;
    logic [W-1:0]  e_t_reg, e_f_reg, e_s_reg;
    logic [W-1:0]  e_xu_reg, e_spu_reg, e_xv_reg, e_spv_reg;
    logic          e_zu_reg, e_fu_reg, e_zv_reg, e_fv_reg;
    logic [FW-1:0] f0e, f1e, s0e, s1e;

    assign f0e = {{(W-F+1){first_low[W-1]}}, first_low};
    assign f1e = {{(W-F+1){first_high[W-1]}}, first_high};
    assign s0e = {{(W-F+1){second_low[W-1]}}, second_low};
    assign s1e = {{(W-F+1){second_high[W-1]}}, second_high};

    assign e_miss_next = d_miss_reg
                       | ($signed(d_f_reg) < $signed(f0e)) | ($signed(d_f_reg) > $signed(f1e))
                       | ($signed(d_s_reg) < $signed(s0e)) | ($signed(d_s_reg) > $signed(s1e));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            c_v_reg   <= 1'b0;
            d_v_reg   <= 1'b0;
            e_v_reg   <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg   <= dt_valid;
            b_v_reg   <= a_v_reg;
            c_v_reg   <= b_v_reg;
            d_v_reg   <= c_v_reg;
            e_v_reg   <= d_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_flags_reg <= dt_flags;
            a_t_reg     <= a_t_next;
            a_oa_reg    <= dt_oa;
            a_ob_reg    <= dt_ob;
            a_da_reg    <= dt_da;
            a_db_reg    <= dt_db;
            a_tlo_reg   <= dt_tlo;
            a_thi_reg   <= dt_thi;

            b_miss_reg  <= b_miss_next;
            b_ff_reg    <= a_flags_reg.front_face;
            b_t_reg     <= a_t_reg[W-1:0];
            b_oa_reg    <= a_oa_reg;
            b_ob_reg    <= a_ob_reg;
            b_da_reg    <= a_da_reg;
            b_db_reg    <= a_db_reg;

            c_miss_reg  <= b_miss_reg;
            c_ff_reg    <= b_ff_reg;
            c_t_reg     <= b_t_reg;
            c_oa_reg    <= b_oa_reg;
            c_ob_reg    <= b_ob_reg;
            c_pa_reg    <= c_pa_next;
            c_pb_reg    <= c_pb_next;

            d_miss_reg  <= c_miss_reg;
            d_ff_reg    <= c_ff_reg;
            d_t_reg     <= c_t_reg;
            d_f_reg     <= d_f_next;
            d_s_reg     <= d_s_next;

            e_miss_reg  <= e_miss_next;
            e_ff_reg    <= d_ff_reg;
            e_t_reg     <= d_t_reg;
            e_f_reg     <= d_f_reg[W-1:0];
            e_s_reg     <= d_s_reg[W-1:0];
            e_xu_reg    <= d_f_reg[W-1:0] - first_low;
            e_spu_reg   <= first_high - first_low;
            e_zu_reg    <= first_high == first_low;
            e_fu_reg    <= d_f_reg[W-1:0] == first_high;
            e_xv_reg    <= d_s_reg[W-1:0] - second_low;
            e_spv_reg   <= second_high - second_low;
            e_zv_reg    <= second_high == second_low;
            e_fv_reg    <= d_s_reg[W-1:0] == second_high;
        end
    end

    // u and v divisions; a point on the high edge gives one and a zero span gives zero,
    // so a divider quotient is used only when the remainder is below the span.
    logic              du_valid;
    logic [F-1:0]      du_quo, dv_quo;
    logic [SIDE_U-1:0] du_side;
    logic [1:0]        dv_side;
    logic              du_miss, du_ff, du_zu, du_fu;
    logic [W-1:0]      du_t, du_f, du_s;

    rai_div #(.NW(F), .DW(W), .SW(SIDE_U)) u_div_u (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (e_v_reg),
        .in_rem   (e_xu_reg),
        .in_num   ({F{1'b0}}),
        .in_den   (e_spu_reg),
        .in_side  ({e_miss_reg, e_ff_reg, e_t_reg, e_f_reg, e_s_reg, e_zu_reg, e_fu_reg}),
        .out_valid(du_valid),
        .out_quo  (du_quo),
        .out_side (du_side)
    );

    rai_div #(.NW(F), .DW(W), .SW(2)) u_div_v (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (e_v_reg),
        .in_rem   (e_xv_reg),
        .in_num   ({F{1'b0}}),
        .in_den   (e_spv_reg),
        .in_side  ({e_zv_reg, e_fv_reg}),
        .out_valid(),
        .out_quo  (dv_quo),
        .out_side (dv_side)
    );

    assign {du_miss, du_ff, du_t, du_f, du_s, du_zu, du_fu} = du_side;

    logic [F:0] u_next, v_next;

    always_comb
    begin
        priority if (du_miss || du_zu)
            u_next = '0;
        else if (du_fu)
            u_next = {1'b1, {F{1'b0}}};
        else
            u_next = {1'b0, du_quo};

        priority if (du_miss || dv_side[1])
            v_next = '0;
        else if (dv_side[0])
            v_next = {1'b1, {F{1'b0}}};
        else
            v_next = {1'b0, dv_quo};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= du_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit        <= ~du_miss;
            hit_t      <= du_miss ? '0 : du_t;
            hit_first  <= du_miss ? '0 : du_f;
            hit_second <= du_miss ? '0 : du_s;
            tex_u      <= u_next;
            tex_v      <= v_next;
            front_face <= ~du_miss & du_ff;
        end
    end

endmodule

>>> hw/rtl/ray_axis_rect_intersect.sv
// Ray versus axis-aligned rectangle test, streaming, one ray per cycle sustained
// while the output is not stalled. The pipeline holds two bit-per-stage dividers
// (Q16.16 by default): WORD_BITS+FRAC_BITS stages for t, FRAC_BITS stages for u/v.
// Asynchronous active-low reset empties the pipeline and loads the default rectangle.
// The user must write configuration only while no transfer is in flight (unchecked).
module ray_axis_rect_intersect
    import rai_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // Fields from bit 0 up: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // t_lower, t_upper.
    input  logic [8*WORD_BITS-1:0]  s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // Fields from bit 0 up: hit_t, hit_first, hit_second, tex_u, tex_v, front_face,
    // zero fill to a whole byte.
    output logic [((3*WORD_BITS+2*FRAC_BITS+3+7)/8)*8-1:0] m_axis_tdata,
    // Fields: hit.
    output logic                    m_axis_tuser,
    input  logic                    cfg_we,
    input  logic [REG_IDX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]    cfg_data
);

    localparam int W        = WORD_BITS;
    localparam int F        = FRAC_BITS;
    localparam int OUT_RAW  = 3 * W + 2 * (F + 1) + 1;
    localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8;
    localparam int QW       = FLAG_BITS + (W + F) + 7 * W;
    localparam logic [W-1:0] ONE_Q = {{(W-1){1'b0}}, 1'b1} << F;

    // Rectangle registers.
    logic [1:0]   plane_axis_reg;
    logic [W-1:0] plane_offset_reg;
    logic [W-1:0] first_low_reg, first_high_reg, second_low_reg, second_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_axis_reg   <= AXIS_XY;
            plane_offset_reg <= '0;
            first_low_reg    <= '0;
            first_high_reg   <= ONE_Q;
            second_low_reg   <= '0;
            second_high_reg  <= ONE_Q;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PLANE_AXIS:   plane_axis_reg   <= cfg_data[1:0];
                REG_PLANE_OFFSET: plane_offset_reg <= cfg_data;
                REG_FIRST_LOW:    first_low_reg    <= cfg_data;
                REG_FIRST_HIGH:   first_high_reg   <= cfg_data;
                REG_SECOND_LOW:   second_low_reg   <= cfg_data;
                REG_SECOND_HIGH:  second_high_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Front: axis selection, parallel-ray detection and the t numerator magnitude.
    logic           fr_valid, fr_ready;
    rai_flags_t     fr_flags;
    logic [W+F-1:0] fr_num;
    logic [W-1:0]   fr_den, fr_oa, fr_ob, fr_da, fr_db, fr_tlo, fr_thi;

    rai_front #(.W(W), .F(F)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .origin_x    (s_axis_tdata[W-1:0]),
        .origin_y    (s_axis_tdata[2*W-1:W]),
        .origin_z    (s_axis_tdata[3*W-1:2*W]),
        .dir_x       (s_axis_tdata[4*W-1:3*W]),
        .dir_y       (s_axis_tdata[5*W-1:4*W]),
        .dir_z       (s_axis_tdata[6*W-1:5*W]),
        .t_lower     (s_axis_tdata[7*W-1:6*W]),
        .t_upper     (s_axis_tdata[8*W-1:7*W]),
        .plane_axis  (plane_axis_reg),
        .plane_offset(plane_offset_reg),
        .out_valid   (fr_valid),
        .out_ready   (fr_ready),
        .out_flags   (fr_flags),
        .out_num     (fr_num),
        .out_den     (fr_den),
        .out_oa      (fr_oa),
        .out_ob      (fr_ob),
        .out_da      (fr_da),
        .out_db      (fr_db),
        .out_tlo     (fr_tlo),
        .out_thi     (fr_thi)
    );

    // The queue lets the front keep taking rays for a while when the output stalls.
    logic          q_valid, q_ready;
    logic [QW-1:0] q_data;
    rai_flags_t    q_flags;
    logic [W+F-1:0] q_num;
    logic [W-1:0]  q_den, q_oa, q_ob, q_da, q_db, q_tlo, q_thi;

    rai_fifo #(.DW(QW), .DEPTH(2)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (fr_valid),
        .in_ready (fr_ready),
        .in_data  ({fr_flags, fr_num, fr_den, fr_oa, fr_ob, fr_da, fr_db, fr_tlo, fr_thi}),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_data (q_data)
    );

    assign {q_flags, q_num, q_den, q_oa, q_ob, q_da, q_db, q_tlo, q_thi} = q_data;

    // Back: the whole pipeline advances whenever the output register is free or taken.
    logic         hit;
    logic [W-1:0] hit_t, hit_first, hit_second;
    logic [F:0]   tex_u, tex_v;
    logic         front_face;

    rai_back #(.W(W), .F(F)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_flags   (q_flags),
        .in_num     (q_num),
        .in_den     (q_den),
        .in_oa      (q_oa),
        .in_ob      (q_ob),
        .in_da      (q_da),
        .in_db      (q_db),
        .in_tlo     (q_tlo),
        .in_thi     (q_thi),
        .first_low  (first_low_reg),
        .first_high (first_high_reg),
        .second_low (second_low_reg),
        .second_high(second_high_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .hit        (hit),
        .hit_t      (hit_t),
        .hit_first  (hit_first),
        .hit_second (hit_second),
        .tex_u      (tex_u),
        .tex_v      (tex_v),
        .front_face (front_face)
    );

    assign m_axis_tdata = {{(OUT_BITS - OUT_RAW){1'b0}},
                           front_face, tex_v, tex_u, hit_second, hit_first, hit_t};
    assign m_axis_tuser = hit;

endmodule
